FILE: design/prc_pkg.sv
`timescale 1ns / 1ps
package prc_pkg;

  localparam int MAX_TILES = 16;
  localparam int TILE_W    = 4;
  localparam int PERM_W    = 64;
  localparam int CODE_W    = 49;
  localparam int ERR_W     = 5;

  typedef logic [TILE_W-1:0] tile_t;
  typedef tile_t [MAX_TILES-1:0] list_t;

  typedef struct packed {
    logic              mode;
    logic [PERM_W-1:0] perm_in;
    logic [CODE_W-1:0] code_in;
    logic [PERM_W-1:0] perm_acc;
    logic [CODE_W-1:0] code_acc;
    logic [ERR_W-1:0]  err;
    list_t             list;
  } item_t;

  // Smallest width w with 2^w >= r
  function automatic int digit_width(input int r);
    int w;
    w = 0;
    while (w < 5 && (1 << w) < r) w++;
    return w;
  endfunction

  // Bit position of digit i in the packed code
  function automatic int digit_offset(input int tiles, input int i);
    int sum;
    sum = 0;
    for (int k = 0; k < i; k++) sum += digit_width(tiles - k);
    return sum;
  endfunction

endpackage

FILE: design/prc_stage.sv
`timescale 1ns / 1ps
module prc_stage #(
  parameter int STEP  = 0,
  parameter int TILES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  prc_pkg::item_t in_item,
  output logic          out_vld,
  output prc_pkg::item_t out_item
);

  localparam int R   = TILES - STEP;
  localparam int W   = prc_pkg::digit_width(R);
  localparam int OFS = prc_pkg::digit_offset(TILES, STEP);

  prc_pkg::tile_t tile;
  logic           found;
  logic [3:0]     hit_idx;
  logic [4:0]     raw5;
  logic           bad;
  logic [3:0]     digit;
  logic           err_inc;
  prc_pkg::list_t list_next;
  prc_pkg::item_t item_next;

  assign tile = in_item.perm_in[prc_pkg::TILE_W*STEP +: prc_pkg::TILE_W];

  // Search the live part of the list; entries are distinct
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int j = prc_pkg::MAX_TILES - 1; j >= 0; j--) begin
      if (j < R && in_item.list[j] == tile) begin
        found   = 1'b1;
        hit_idx = 4'(j);
      end
    end
  end

  generate
    if (W > 0) begin : g_dig
      assign raw5 = 5'(in_item.code_in[OFS +: W]);
    end else begin : g_nodig
      assign raw5 = '0;
    end
  endgenerate

  assign bad     = raw5 >= 5'(R);
  assign digit   = in_item.mode ? (bad ? 4'd0 : raw5[3:0]) : (found ? hit_idx : 4'd0);
  assign err_inc = in_item.mode ? bad : !found;

  // Drop the used entry and close the gap
  always_comb begin
    int src;
    for (int k = 0; k < prc_pkg::MAX_TILES; k++) begin
      src = (k + 1 < R && 4'(k) >= digit) ? k + 1 : k;
      list_next[k] = in_item.list[4'(src)];
    end
  end

  always_comb begin
    item_next      = in_item;
    item_next.list = list_next;
    item_next.err  = in_item.err + prc_pkg::ERR_W'(err_inc);
    if (in_item.mode) begin
      item_next.perm_acc[prc_pkg::TILE_W*STEP +: prc_pkg::TILE_W] = in_item.list[digit];
    end else begin
      item_next.code_acc = in_item.code_acc
                         | (prc_pkg::CODE_W'(digit) << OFS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= item_next;
  end

endmodule

FILE: design/permutation_rank_codec_top.sv
`timescale 1ns / 1ps
// Permutation rank codec: ranks a permutation of TILES four-bit tiles into a
// packed mixed-radix Lehmer code (mode 0) or unranks a code into a
// permutation (mode 1).
// Input: a beat is taken at each rising edge with start high and busy low.
// busy stays low, so a new beat may be issued in every cycle.
// Output: done is high for exactly one cycle with perm_out, code_out and
// error_count valid in that cycle; results leave in input order.
// Pipeline: one entry register, then one stage per digit, each stage
// searching and shrinking the list of unused tiles. Throughput: one beat
// per cycle, set by the one-digit-per-stage pipeline.
// Reset (rst, synchronous) clears all stage valid bits; beats in flight are
// dropped. The receiver cannot stall, so the pipeline never holds.
// error_count counts tiles not found in the list (encode) or digits out of
// range (decode).
module permutation_rank_codec_top #(
  parameter int TILES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [63:0] perm_in,
  input  logic [48:0] code_in,
  output logic        done,
  output logic [63:0] perm_out,
  output logic [48:0] code_out,
  output logic [4:0]  error_count
);

  prc_pkg::item_t       pipe [0:TILES];
  logic [TILES:0]       vld;
  prc_pkg::item_t       entry_next;

  assign busy = 1'b0;

  always_comb begin
    entry_next          = '0;
    entry_next.mode     = mode;
    entry_next.perm_in  = perm_in;
    entry_next.code_in  = code_in;
    for (int k = 0; k < prc_pkg::MAX_TILES; k++) begin
      entry_next.list[k] = prc_pkg::tile_t'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pipe[0] <= entry_next;
  end

  generate
    for (genvar s = 0; s < TILES; s++) begin : g_stage
      prc_stage #(
        .STEP  (s),
        .TILES (TILES)
      ) u_stage (
        .clk      (clk),
        .rst      (rst),
        .in_vld   (vld[s]),
        .in_item  (pipe[s]),
        .out_vld  (vld[s+1]),
        .out_item (pipe[s+1])
      );
    end
  endgenerate

  assign done        = vld[TILES];
  assign perm_out    = pipe[TILES].perm_acc;
  assign code_out    = pipe[TILES].code_acc;
  assign error_count = pipe[TILES].err;

endmodule

FILE: tb/sv/tb_permutation_rank_codec_top.sv
`timescale 1ns / 1ps
module tb_permutation_rank_codec_top;
  import prc_pkg::*;

  localparam int TILES       = 16;
  localparam int LATENCY     = TILES + 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 1100;

  localparam bit MODE_RANK   = 1'b0;
  localparam bit MODE_UNRANK = 1'b1;

  typedef enum int {DIGITS_TOP, DIGITS_VALID, DIGITS_WILD} digit_pick_t;

  typedef struct packed {
    logic [PERM_W-1:0] perm;
    logic [CODE_W-1:0] code;
    logic [ERR_W-1:0]  errs;
  } codec_result_t;

  // Packed width of a digit with r possible values
  function automatic int digit_bits(input int r);
    return (r > 8) ? 4 : (r > 4) ? 3 : (r > 2) ? 2 : (r > 1) ? 1 : 0;
  endfunction

  class codec_scoreboard;
    codec_result_t awaited[$];
    int unsigned   fails;

    function codec_result_t rank_perm(input logic [PERM_W-1:0] p);
      tile_t         pool[MAX_TILES];
      codec_result_t res;
      int            r, d, off;
      bit            hit;
      res = '0;
      off = 0;
      for (int k = 0; k < MAX_TILES; k++) pool[k] = tile_t'(k);
      for (int i = 0; i < TILES; i++) begin
        r = TILES - i;
        d = 0;
        hit = 0;
        for (int j = 0; j < r; j++) begin
          if (!hit && pool[j] == p[4*i +: 4]) begin
            d = j;
            hit = 1;
          end
        end
        // missing tile: digit 0, drop the head of the pool
        if (!hit) res.errs = res.errs + 1'b1;
        res.code = res.code | (CODE_W'(d) << off);
        for (int k = d; k + 1 < r; k++) pool[k] = pool[k+1];
        off += digit_bits(r);
      end
      return res;
    endfunction

    function codec_result_t unrank_code(input logic [CODE_W-1:0] c);
      tile_t         pool[MAX_TILES];
      codec_result_t res;
      int            r, w, d, off;
      res = '0;
      off = 0;
      for (int k = 0; k < MAX_TILES; k++) pool[k] = tile_t'(k);
      for (int i = 0; i < TILES; i++) begin
        r = TILES - i;
        w = digit_bits(r);
        d = (w == 0) ? 0 : int'((c >> off) & ((CODE_W'(1) << w) - 1));
        if (d >= r) begin
          d = 0;
          res.errs = res.errs + 1'b1;
        end
        res.perm[4*i +: 4] = pool[d];
        for (int k = d; k + 1 < r; k++) pool[k] = pool[k+1];
        off += w;
      end
      return res;
    endfunction

    function void note_beat(input bit m, input logic [PERM_W-1:0] p,
                            input logic [CODE_W-1:0] c);
      awaited.push_back((m == MODE_UNRANK) ? unrank_code(c) : rank_perm(p));
    endfunction

    function void check_result(input logic [PERM_W-1:0] p, input logic [CODE_W-1:0] c,
                               input logic [ERR_W-1:0] e);
      codec_result_t exp_res;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result perm=%h code=%h errors=%0d", $time, p, c, e);
        fails++;
        return;
      end
      exp_res = awaited.pop_front();
      if (p !== exp_res.perm) begin
        $display("%0t: perm_out expected %h actual %h", $time, exp_res.perm, p);
        fails++;
      end
      if (c !== exp_res.code) begin
        $display("%0t: code_out expected %h actual %h", $time, exp_res.code, c);
        fails++;
      end
      if (e !== exp_res.errs) begin
        $display("%0t: error_count expected %0d actual %0d", $time, exp_res.errs, e);
        fails++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              mode;
  logic [PERM_W-1:0] perm_in;
  logic [CODE_W-1:0] code_in;
  logic              done;
  logic [PERM_W-1:0] perm_out;
  logic [CODE_W-1:0] code_out;
  logic [ERR_W-1:0]  error_count;

  codec_scoreboard sb = new;
  int              idle_pct;

  permutation_rank_codec_top #(.TILES(TILES)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .perm_in     (perm_in),
    .code_in     (code_in),
    .done        (done),
    .perm_out    (perm_out),
    .code_out    (code_out),
    .error_count (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_beat(mode, perm_in, code_in);
    if (!rst && done) sb.check_result(perm_out, code_out, error_count);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    return CODE_W'(rand64());
  endfunction

  function automatic logic [PERM_W-1:0] random_perm();
    tile_t             pool[MAX_TILES];
    tile_t             tmp;
    logic [PERM_W-1:0] p;
    int                j;
    for (int k = 0; k < MAX_TILES; k++) pool[k] = tile_t'(k);
    for (int k = MAX_TILES - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
    end
    p = '0;
    for (int k = 0; k < MAX_TILES; k++) p[4*k +: 4] = pool[k];
    return p;
  endfunction

  function automatic logic [CODE_W-1:0] build_code(input digit_pick_t pick);
    logic [CODE_W-1:0] c;
    int                r, w, d, off;
    c = '0;
    off = 0;
    for (int i = 0; i < TILES; i++) begin
      r = TILES - i;
      w = digit_bits(r);
      case (pick)
        DIGITS_TOP:   d = r - 1;
        DIGITS_VALID: d = $urandom_range(0, r - 1);
        default:      d = (w == 0) ? 0 : $urandom_range(0, (1 << w) - 1);
      endcase
      c = c | (CODE_W'(d) << off);
      off += w;
    end
    return c;
  endfunction

  task automatic send_beat(input bit m, input logic [PERM_W-1:0] p,
                           input logic [CODE_W-1:0] c);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      mode    <= 1'($urandom_range(0, 1));
      perm_in <= rand64();
      @(negedge clk);
    end
    start   <= 1'b1;
    mode    <= m;
    perm_in <= p;
    code_in <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    logic [PERM_W-1:0] p;
    int                a, b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_beat(MODE_RANK, random_perm(), rand_code());
      4, 5, 6:    send_beat(MODE_UNRANK, rand64(), build_code(DIGITS_VALID));
      7: begin
        // copy one tile over another, a duplicate unless both picks are equal
        p = random_perm();
        a = $urandom_range(0, TILES - 1);
        b = $urandom_range(0, TILES - 1);
        p[4*b +: 4] = p[4*a +: 4];
        send_beat(MODE_RANK, p, rand_code());
      end
      8:       send_beat(MODE_RANK, rand64(), rand_code());
      default: send_beat(MODE_UNRANK, rand64(),
                         $urandom_range(0, 1) ? build_code(DIGITS_WILD) : rand_code());
    endcase
  endtask

  initial begin
    int phase_idle[4];
    int tail;
    phase_idle = '{0, 50, 0, 20};
    rst      = 1'b1;
    start    = 1'b0;
    mode     = MODE_RANK;
    perm_in  = '0;
    code_in  = '0;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(MODE_RANK, 64'hFEDC_BA98_7654_3210, rand_code());
    send_beat(MODE_RANK, 64'h0123_4567_89AB_CDEF, rand_code());
    send_beat(MODE_RANK, 64'h0, rand_code());
    send_beat(MODE_RANK, 64'hFFFF_FFFF_FFFF_FFFF, rand_code());
    send_beat(MODE_RANK, 64'hFEDC_BA98_7654_3200, rand_code());
    send_beat(MODE_RANK, 64'hEFDC_BA98_7654_3210, rand_code());
    send_beat(MODE_RANK, random_perm(), '0);
    send_beat(MODE_UNRANK, rand64(), '0);
    send_beat(MODE_UNRANK, rand64(), {CODE_W{1'b1}});
    send_beat(MODE_UNRANK, rand64(), build_code(DIGITS_TOP));
    // out-of-range digit in the first three-bit slot that can overflow
    send_beat(MODE_UNRANK, rand64(), CODE_W'(7) << 35);
    send_beat(MODE_UNRANK, rand64(), CODE_W'(3) << 46);
    send_beat(MODE_UNRANK, rand64(), CODE_W'(1) << 48);
    send_beat(MODE_UNRANK, '0, build_code(DIGITS_VALID));
    send_beat(MODE_UNRANK, 64'hFFFF_FFFF_FFFF_FFFF, build_code(DIGITS_WILD));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int n = 0; n < RAND_ITEMS / 4; n++) send_random();
    end

    @(negedge clk);
    start <= 1'b0;
    tail = 0;
    while (sb.awaited.size() != 0 && tail < 20 * LATENCY) begin
      @(posedge clk);
      tail++;
    end
    repeat (3 * LATENCY) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.awaited.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
